>>> rtl/core/stlm_pkg.sv
// shared constants and types of the sorted top-k list merge
package stlm_pkg;

  localparam int MaxNeighbors = 32;
  localparam int IdxW = (MaxNeighbors > 1) ? $clog2(MaxNeighbors) : 1;

  localparam int DistW = 32;
  localparam int PointW = 31;

  localparam int InFieldW = 2 * (DistW + PointW);
  localparam int InDataW = ((InFieldW + 7) / 8) * 8;
  localparam int OutFieldW = DistW + PointW;
  localparam int OutDataW = ((OutFieldW + 7) / 8) * 8;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(MaxNeighbors - 1);

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [DistW-1:0] dist_t;
  typedef logic [PointW-1:0] point_t;

  typedef struct packed {
    point_t point;
    dist_t  distance;
  } entry_t;

endpackage

>>> rtl/core/sorted_topk_list_merge.sv
// merge of two ascending neighbor lists, keeping the k smallest
// Each input word carries entry j of the old list and entry j of the new list of one query
// row; the block stores both and returns merged entry j (the smaller of the two list heads,
// the new entry on a tie) in the cycle after the word is accepted. It takes one word every
// cycle while the output register is empty or read in that same cycle; a result that waits
// unread on the output side stalls the input. The rate is set by the head compare and
// pointer update. tlast on the input closes a row; a row reaching MaxNeighbors entries
// closes on its own. The two stores are flip-flop arrays that need no clearing after
// reset; only entries written earlier in the same row are ever read.
module sorted_topk_list_merge
  import stlm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // old_distance, old_point, new_distance, new_point, zero fill
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // last_of_row
  input  logic                s_axis_tlast_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // merged_distance, merged_point, zero fill
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // row_done
  output logic                m_axis_tlast_o
);

  entry_t old_in, new_in;
  entry_t old_store_q [MaxNeighbors];
  entry_t new_store_q [MaxNeighbors];
  entry_t old_head, new_head, merged;
  idx_t   old_ptr_q, old_ptr_d, new_ptr_q, new_ptr_d, wr_idx;
  logic [IdxW:0] ptr_sum;
  logic   s_acc, take_old, done;
  logic   out_valid_q, out_valid_d;
  entry_t out_q;
  logic   out_last_q;

  assign old_in.distance = s_axis_tdata_i[DistW-1:0];
  assign old_in.point    = s_axis_tdata_i[DistW+PointW-1:DistW];
  assign new_in.distance = s_axis_tdata_i[2*DistW+PointW-1:DistW+PointW];
  assign new_in.point    = s_axis_tdata_i[2*DistW+2*PointW-1:2*DistW+PointW];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  assign ptr_sum = {1'b0, old_ptr_q} + {1'b0, new_ptr_q};
  assign wr_idx  = ptr_sum[IdxW-1:0];

  // a head sits at the slot being written when the other list has not moved yet
  assign old_head = (new_ptr_q == '0) ? old_in : old_store_q[old_ptr_q];
  assign new_head = (old_ptr_q == '0) ? new_in : new_store_q[new_ptr_q];

  assign take_old = old_head.distance < new_head.distance;
  assign merged   = take_old ? old_head : new_head;
  assign done     = s_axis_tlast_i || (wr_idx == LastIdx);

  always_comb begin
    old_ptr_d = old_ptr_q;
    new_ptr_d = new_ptr_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (s_acc) begin
      out_valid_d = 1'b1;
      if (done) begin
        old_ptr_d = '0;
        new_ptr_d = '0;
      end else if (take_old) begin
        old_ptr_d = old_ptr_q + idx_t'(1);
      end else begin
        new_ptr_d = new_ptr_q + idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_ptr_q   <= '0;
      new_ptr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      old_ptr_q   <= old_ptr_d;
      new_ptr_q   <= new_ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      old_store_q[wr_idx] <= old_in;
      new_store_q[wr_idx] <= new_in;
      out_q      <= merged;
      out_last_q <= done;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataW'({out_q.point, out_q.distance});
  assign m_axis_tlast_o  = out_last_q;

`ifndef NO_ASSERTIONS
  // both pointers together never run past the last slot
  a_ptr_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_sum <= (IdxW+1)'(MaxNeighbors - 1))
    else $error("pointer sum beyond list length");

  // a word that closes the row leaves both pointers cleared
  a_row_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && done |=> (old_ptr_q == '0) && (new_ptr_q == '0))
    else $error("pointers not cleared at end of row");

  // inside a row exactly one pointer advances per word
  a_one_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && !done |=> ptr_sum == $past(ptr_sum) + (IdxW+1)'(1))
    else $error("merge did not advance by one entry");

  // every accepted word yields a result in the next cycle
  a_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> m_axis_tvalid_o && (m_axis_tlast_o == $past(done)))
    else $error("result missing after accepted word");
`endif

endmodule

>>> sim/sorted_topk_list_merge_checker.sv
// checker that predicts each merged word of the list merge and compares it with the block
`timescale 1ns / 100ps

module sorted_topk_list_merge_checker
  import stlm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  // old_distance, old_point, new_distance, new_point, zero fill
  input  logic [InDataW-1:0]  s_tdata_i,
  // last_of_row
  input  logic                s_tlast_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  // merged_distance, merged_point, zero fill
  input  logic [OutDataW-1:0] m_tdata_i,
  // row_done
  input  logic                m_tlast_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct packed {
    dist_t  distance;
    point_t point;
    logic   done;
  } merged_t;

  dist_t  old_dists  [MaxNeighbors];
  point_t old_points [MaxNeighbors];
  dist_t  new_dists  [MaxNeighbors];
  point_t new_points [MaxNeighbors];
  idx_t   old_head;
  idx_t   new_head;

  merged_t merged_q[$];
  int      fails;

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_compare
    idx_t    slot;
    merged_t want;
    if (!rst_ni) begin
      old_head = '0;
      new_head = '0;
      merged_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        // entry j lands at old_head + new_head, both heads stay at or below it
        slot = old_head + new_head;
        old_dists[slot]  = s_tdata_i[DistW-1:0];
        old_points[slot] = s_tdata_i[DistW +: PointW];
        new_dists[slot]  = s_tdata_i[DistW+PointW +: DistW];
        new_points[slot] = s_tdata_i[2*DistW+PointW +: PointW];
        // the new entry wins a tie
        if (old_dists[old_head] < new_dists[new_head]) begin
          want.distance = old_dists[old_head];
          want.point    = old_points[old_head];
          old_head      = old_head + 1'b1;
        end else begin
          want.distance = new_dists[new_head];
          want.point    = new_points[new_head];
          new_head      = new_head + 1'b1;
        end
        // a row that fills the stores closes whatever tlast says
        want.done = s_tlast_i || (slot == LastIdx);
        if (want.done) begin
          old_head = '0;
          new_head = '0;
        end
        merged_q.push_back(want);
      end
      if (m_tvalid_i && m_tready_i) begin
        if (merged_q.size() == 0) begin
          fails++;
          $error("merged word 0x%h arrived with none expected", m_tdata_i);
        end else begin
          want = merged_q.pop_front();
          if (m_tdata_i[DistW-1:0] !== want.distance) begin
            fails++;
            $error("merged_distance: expected 0x%h, got 0x%h", want.distance,
                   m_tdata_i[DistW-1:0]);
          end
          if (m_tdata_i[DistW +: PointW] !== want.point) begin
            fails++;
            $error("merged_point: expected 0x%h, got 0x%h", want.point,
                   m_tdata_i[DistW +: PointW]);
          end
          if (m_tlast_i !== want.done) begin
            fails++;
            $error("row_done: expected %0b, got %0b", want.done, m_tlast_i);
          end
        end
      end
      fail_count_o <= fails;
      pending_o <= merged_q.size();
    end
  end

endmodule

>>> sim/sorted_topk_list_merge_tb.sv
// testbench top: drives rows of sorted neighbor lists into the merge and reports the verdict
`timescale 1ns / 100ps

module sorted_topk_list_merge_tb;
  import stlm_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int PhaseItems = 225;

  logic clk = 1'b0;
  logic rst_n;

  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic                s_tlast;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tlast;

  int fail_count;
  int pending;
  int items;
  int idle_pct;
  int stall_pct;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_topk_list_merge i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  sorted_topk_list_merge_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tlast_i    (s_tlast),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tlast_i    (m_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // offers one word, with random idle cycles ahead of it, and waits for its handshake
  task automatic send_word(input dist_t od, input point_t op, input dist_t nd,
                           input point_t np, input logic last);
    if ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= InDataW'({np, nd, op, od});
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    items++;
  endtask

  function automatic int unsigned pick_step();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 2;
      2: return 1000;
      3: return 32'h0100_0000;
      default: return 32'h0800_0000;
    endcase
  endfunction

  // ascending step that sticks at the top instead of wrapping
  function automatic dist_t next_ascending(dist_t d, int unsigned step);
    logic [DistW:0] sum;
    sum = {1'b0, d} + $urandom_range(0, step);
    return sum[DistW] ? '1 : sum[DistW-1:0];
  endfunction

  // one query row of two ascending lists; close marks the final entry with tlast
  task automatic send_row(input int len, input logic close);
    dist_t       od;
    dist_t       nd;
    int unsigned old_step;
    int unsigned new_step;
    old_step = pick_step();
    new_step = pick_step();
    od = $urandom >> $urandom_range(0, 31);
    nd = ($urandom_range(0, 2) == 0) ? od : ($urandom >> $urandom_range(0, 31));
    for (int j = 0; j < len; j++) begin
      send_word(od, point_t'($urandom), nd, point_t'($urandom), close && (j == len - 1));
      od = next_ascending(od, old_step);
      nd = next_ascending(nd, new_step);
    end
  endtask

  initial begin : stimulus
    int phase_end;
    rst_n    = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    items = 0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-entry rows: tie at the top, old smallest, new smallest
    send_word('1, '1, '1, '0, 1'b1);
    send_word('0, '0, '1, '1, 1'b1);
    send_word('1, 31'd1, '0, 31'd2, 1'b1);
    // all distances equal, so the new list drains first
    for (int j = 0; j < 4; j++) send_word('0, point_t'(j), '0, point_t'(j + 100), j == 3);
    // old list entirely below the new one
    for (int j = 0; j < 4; j++) begin
      send_word(dist_t'(j + 1), point_t'(j + 1), dist_t'((j + 1) * 10), point_t'(j + 50), j == 3);
    end
    // interleaved lists
    for (int j = 0; j < 4; j++) begin
      send_word(dist_t'(j * 10), point_t'(j), dist_t'(j * 10 + 5), point_t'(j + 9), j == 3);
    end
    send_word(32'h5555_5555, 31'h2AAA_AAAA, 32'hAAAA_AAAA, 31'h5555_5555, 1'b0);
    send_word(32'hAAAA_AAAA, 31'h5555_5555, 32'hFFFF_FFFE, 31'h2AAA_AAAA, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      phase_end = items + PhaseItems;
      while (items < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: send_row($urandom_range(1, 32), 1'b1);
          6: send_row(MaxNeighbors, 1'b1);
          // no tlast: the row closes itself when the stores fill
          7: send_row(MaxNeighbors, 1'b0);
          8: send_row($urandom_range(MaxNeighbors + 1, MaxNeighbors + 8), 1'b0);
          default: begin
            repeat ($urandom_range(1, 8)) begin
              send_word(dist_t'($urandom), point_t'($urandom), dist_t'($urandom),
                        point_t'($urandom), $urandom_range(0, 3) == 0);
            end
          end
        endcase
      end
    end

    s_tvalid <= 1'b0;
    // let the checker count the last word before looking at what is pending
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
